FILE: hdl/bxtd_pkg.sv
// bxtd_pkg: shared types, constants and helpers for the binary xml token decoder
`default_nettype none
package bxtd_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int OFFSET_BITS = 32;
  localparam int DEPTH_BITS  = 8;
  localparam int OVF_BITS    = 10;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [VALUE_BITS-1:0]  value_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [DEPTH_BITS-1:0]  depth_t;

  typedef enum logic [2:0] {
    PH_INITIAL  = 3'd0,
    PH_NEWTOKEN = 3'd1,
    PH_NUMVAL   = 3'd2,
    PH_TAGNAME  = 3'd3,
    PH_ATTRNAME = 3'd4,
    PH_UDATA    = 3'd5,
    PH_BLOB     = 3'd6,
    PH_ERROR    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    TT_EXT   = 3'd0,
    TT_TAG   = 3'd1,
    TT_DTAG  = 3'd2,
    TT_ATTR  = 3'd3,
    TT_DATTR = 3'd4,
    TT_BLOB  = 3'd5,
    TT_UDATA = 3'd6,
    TT_CLOSE = 3'd7
  } tok_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NEST     = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_ATTR     = 3'd3,
    ERR_CODING   = 3'd4
  } err_t;

  localparam logic [1:0] TC_NONE = 2'd0;
  localparam logic [1:0] TC_TAG  = 2'd1;
  localparam logic [1:0] TC_ATTR = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] byte_offset;
    logic        token_done;
    logic [2:0]  token_type;
    logic [31:0] token_value;
    logic [31:0] token_start;
    logic [31:0] element_start;
    logic [7:0]  depth;
    logic        in_payload;
    logic        message_done;
    logic [2:0]  error_code;
  } out_beat_t;

  // classified byte passed from front to back
  typedef struct packed {
    offset_t    offset;
    logic       restart;
    logic       is_close;
    logic       is_final;
    tok_t       tok;
    logic [6:0] low7;
    logic [3:0] nib;
  } tok_beat_t;

  function automatic logic [31:0] off_out(offset_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic logic [31:0] val_out(value_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic logic [7:0] depth_out(depth_t v);
    logic [15:0] w;
    w = 16'(v);
    return w[7:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bxtd_front.sv
// bxtd_front: input stage, byte offset counter and byte classification
`default_nettype none
module bxtd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bxtd_pkg::in_beat_t  in_data,
  output logic                     fb_valid,
  input  wire logic                fb_ready,
  output bxtd_pkg::tok_beat_t      fb_data
);
  import bxtd_pkg::*;

  logic      valid_r, valid_nxt;
  offset_t   count_r, count_nxt;
  tok_beat_t beat_r, beat_nxt;
  offset_t   off;
  logic      take;

  assign in_ready = !valid_r || fb_ready;
  assign take     = in_valid && in_ready;
  assign off      = in_data.restart ? '0 : count_r;

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    beat_nxt  = beat_r;
    if (fb_ready) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt         = 1'b1;
      count_nxt         = off + offset_t'(1);
      beat_nxt.offset   = off;
      beat_nxt.restart  = in_data.restart;
      beat_nxt.is_close = (in_data.data_byte == 8'h00);
      beat_nxt.is_final = in_data.data_byte[7];
      beat_nxt.tok      = tok_t'(in_data.data_byte[2:0]);
      beat_nxt.low7     = in_data.data_byte[6:0];
      beat_nxt.nib      = in_data.data_byte[6:3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
    beat_r <= beat_nxt;
  end

  assign fb_valid = valid_r;
  assign fb_data  = beat_r;

endmodule
`default_nettype wire

FILE: hdl/bxtd_queue.sv
// bxtd_queue: short queue of classified bytes between front and back
`default_nettype none
module bxtd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire bxtd_pkg::tok_beat_t  push_data,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output bxtd_pkg::tok_beat_t       pop_data
);
  import bxtd_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  tok_beat_t           slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                push, pop;

  assign push_ready = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bxtd_back.sv
// bxtd_back: token decoder state machine and result register
`default_nettype none
module bxtd_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 bk_valid,
  output logic                      bk_ready,
  input  wire bxtd_pkg::tok_beat_t  bk_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output bxtd_pkg::out_beat_t       out_data
);
  import bxtd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] tc_r, tc_nxt;
  value_t     pend_r, pend_nxt;
  depth_t     depth_r, depth_nxt;
  offset_t    tbeg_r, tbeg_nxt;
  offset_t    ebeg_r, ebeg_nxt;
  err_t       serr_r, serr_nxt;
  logic       ovalid_r, ovalid_nxt;
  out_beat_t  obeat_r, obeat_nxt;

  logic       step;
  err_t       err;
  logic       header, done, pay, msg;
  tok_t       tt;
  value_t     tval;

  assign bk_ready = !ovalid_r || out_ready;
  assign step     = bk_valid && bk_ready;

  always_comb begin
    phase_nxt = bk_data.restart ? PH_INITIAL : phase_r;
    tc_nxt    = bk_data.restart ? TC_NONE : tc_r;
    pend_nxt  = bk_data.restart ? '0 : pend_r;
    depth_nxt = bk_data.restart ? '0 : depth_r;
    tbeg_nxt  = bk_data.restart ? '0 : tbeg_r;
    ebeg_nxt  = bk_data.restart ? '0 : ebeg_r;
    serr_nxt  = bk_data.restart ? ERR_NONE : serr_r;
    err    = ERR_NONE;
    header = 1'b0;
    done   = 1'b0;
    pay    = 1'b0;
    msg    = 1'b0;
    tt     = TT_EXT;
    tval   = '0;

    unique case (phase_nxt)
      PH_INITIAL, PH_NEWTOKEN: begin
        tbeg_nxt = bk_data.offset;
        if (tc_nxt > TC_TAG) begin
          tc_nxt = tc_nxt - 2'd1;
        end
        if (bk_data.is_close) begin
          if (depth_nxt == '0 || tc_nxt > TC_TAG) begin
            err = ERR_NEST;
          end else begin
            if (tc_nxt == TC_TAG) begin
              tc_nxt = TC_NONE;
            end
            depth_nxt = depth_nxt - depth_t'(1);
            done      = 1'b1;
            tt        = TT_CLOSE;
            if (depth_nxt == '0) begin
              phase_nxt = PH_INITIAL;
              msg       = 1'b1;
            end else begin
              phase_nxt = PH_NEWTOKEN;
            end
          end
        end else begin
          pend_nxt  = '0;
          phase_nxt = PH_NUMVAL;
          header    = 1'b1;
        end
      end
      PH_NUMVAL: begin
        header = 1'b1;
      end
      PH_TAGNAME, PH_ATTRNAME, PH_UDATA, PH_BLOB: begin
        pay = 1'b1;
        if (pend_nxt == '0) begin
          err = ERR_CODING;
        end else begin
          pend_nxt = pend_nxt - value_t'(1);
          if (pend_nxt == '0) begin
            priority if (phase_nxt == PH_TAGNAME) begin
              if (depth_nxt == '0) begin
                err = ERR_NEST;
              end else begin
                tc_nxt = TC_TAG;
              end
            end else if (phase_nxt == PH_ATTRNAME) begin
              if (depth_nxt == '0) begin
                err = ERR_ATTR;
              end else begin
                tc_nxt = TC_ATTR;
              end
            end else begin
            end
            phase_nxt = PH_NEWTOKEN;
          end
        end
      end
      PH_ERROR: begin
      end
    endcase

    if (header) begin
      if (!bk_data.is_final) begin
        if (pend_nxt[VALUE_BITS-1 -: OVF_BITS] != '0) begin
          err = ERR_OVERFLOW;
        end
        pend_nxt = {pend_nxt[VALUE_BITS-8:0], bk_data.low7};
      end else begin
        pend_nxt = {pend_nxt[VALUE_BITS-5:0], bk_data.nib};
        unique case (bk_data.tok)
          TT_EXT, TT_DTAG: begin
            if (tc_nxt == TC_TAG) begin
              tc_nxt = TC_NONE;
            end
            if (depth_nxt == '1) begin
              err = ERR_NEST;
            end else begin
              depth_nxt = depth_nxt + depth_t'(1);
              ebeg_nxt  = tbeg_nxt;
            end
            if (bk_data.tok == TT_DTAG) begin
              tc_nxt = TC_TAG;
            end
            phase_nxt = PH_NEWTOKEN;
          end
          TT_TAG: begin
            if (tc_nxt == TC_TAG) begin
              tc_nxt = TC_NONE;
            end
            pend_nxt = pend_nxt + value_t'(1);
            if (depth_nxt == '1) begin
              err = ERR_NEST;
            end else begin
              depth_nxt = depth_nxt + depth_t'(1);
              ebeg_nxt  = tbeg_nxt;
            end
            phase_nxt = PH_TAGNAME;
          end
          TT_ATTR: begin
            if (tc_nxt != TC_TAG) begin
              err = ERR_ATTR;
            end else begin
              pend_nxt  = pend_nxt + value_t'(1);
              phase_nxt = PH_ATTRNAME;
            end
          end
          TT_DATTR: begin
            if (tc_nxt != TC_TAG) begin
              err = ERR_ATTR;
            end else begin
              tc_nxt    = TC_ATTR;
              phase_nxt = PH_NEWTOKEN;
            end
          end
          TT_BLOB, TT_UDATA: begin
            if (tc_nxt == TC_TAG) begin
              tc_nxt = TC_NONE;
            end
            if (pend_nxt == '0) begin
              phase_nxt = PH_NEWTOKEN;
            end else begin
              phase_nxt = (bk_data.tok == TT_BLOB) ? PH_BLOB : PH_UDATA;
            end
          end
          TT_CLOSE: begin
            err = ERR_CODING;
          end
        endcase
        done = 1'b1;
        tt   = bk_data.tok;
        tval = pend_nxt;
      end
    end

    if (err != ERR_NONE) begin
      serr_nxt  = err;
      phase_nxt = PH_ERROR;
      tc_nxt    = TC_NONE;
      done      = 1'b0;
      tt        = TT_EXT;
      tval      = '0;
      msg       = 1'b0;
    end

    obeat_nxt.byte_offset   = off_out(bk_data.offset);
    obeat_nxt.token_done    = done;
    obeat_nxt.token_type    = tt;
    obeat_nxt.token_value   = val_out(tval);
    obeat_nxt.token_start   = off_out(tbeg_nxt);
    obeat_nxt.element_start = off_out(ebeg_nxt);
    obeat_nxt.depth         = depth_out(depth_nxt);
    obeat_nxt.in_payload    = pay;
    obeat_nxt.message_done  = msg;
    obeat_nxt.error_code    = serr_nxt;

    ovalid_nxt = step || (ovalid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_INITIAL;
      tc_r     <= TC_NONE;
      pend_r   <= '0;
      depth_r  <= '0;
      tbeg_r   <= '0;
      ebeg_r   <= '0;
      serr_r   <= ERR_NONE;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (step) begin
        phase_r <= phase_nxt;
        tc_r    <= tc_nxt;
        pend_r  <= pend_nxt;
        depth_r <= depth_nxt;
        tbeg_r  <= tbeg_nxt;
        ebeg_r  <= ebeg_nxt;
        serr_r  <= serr_nxt;
      end
    end
    if (step) begin
      obeat_r <= obeat_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = obeat_r;

endmodule
`default_nettype wire

FILE: hdl/binary_xml_token_decoder_unit.sv
// binary_xml_token_decoder_unit: top level of the binary xml token decoder
//
//   channel  dir  handshake              beat
//   in_      in   in_valid / in_ready    in_beat_t  (data_byte, restart)
//   out_     out  out_valid / out_ready  out_beat_t (one result per byte)
//
// one byte per cycle sustained while out_ready is held high; each input beat passes, in order,
// through the front register, the two-entry queue and the result register
// the decoder state loop in the back stage is combinational and updates once per accepted byte
// rst_n clears the offset counter, queue, decoder state and result valid
// a stalled output holds its beat; the queue lets the front keep taking bytes until it fills
`default_nettype none
module binary_xml_token_decoder_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bxtd_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bxtd_pkg::out_beat_t      out_data
);
  import bxtd_pkg::*;

  logic      fb_valid, fb_ready;
  tok_beat_t fb_data;
  logic      bk_valid, bk_ready;
  tok_beat_t bk_data;

  bxtd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fb_valid (fb_valid),
    .fb_ready (fb_ready),
    .fb_data  (fb_data)
  );

  bxtd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fb_valid),
    .push_ready (fb_ready),
    .push_data  (fb_data),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_data)
  );

  bxtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bk_valid  (bk_valid),
    .bk_ready  (bk_ready),
    .bk_data   (bk_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: hdl/bxtd_checker.sv
// bxtd_checker: port level assertions for the binary xml token decoder
`default_nettype none
module bxtd_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire bxtd_pkg::out_beat_t out_data
);
  import bxtd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_msg_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.message_done |->
      out_data.token_done && out_data.token_type == TT_CLOSE && out_data.depth == 8'd0)
    else $error("message end without close at depth zero");

  a_idle_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.token_done |->
      out_data.token_type == TT_EXT && out_data.token_value == 32'd0)
    else $error("token fields set without token");

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != ERR_NONE |->
      !out_data.token_done && !out_data.message_done)
    else $error("token reported while in error");

endmodule

bind binary_xml_token_decoder_unit bxtd_checker u_bxtd_checker (.*);
`default_nettype wire

FILE: verif/binary_xml_token_decoder_unit_tb.sv
// binary_xml_token_decoder_unit_tb: self-checking testbench for the binary xml token decoder
`timescale 1ns / 100ps
module binary_xml_token_decoder_unit_tb;
  import bxtd_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       typed;
    out_beat_t  want;
  } dir_row_t;

  typedef struct {
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } stim_row_t;

  localparam int     DIR_ROWS     = 29;
  localparam int     RAND_BEATS   = 870;
  localparam value_t OVF_LIMIT    = value_t'({VALUE_BITS{1'b1}}) >> OVF_BITS;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  binary_xml_token_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed bytes; typed rows carry the result read straight off the coding rules
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, '{32'd0, 1'b0, TT_EXT, 32'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0,
                          ERR_NEST}},
    '{8'h82, 1'b1, 1'b1, '{32'd0, 1'b1, TT_DTAG, 32'd0, 32'd0, 32'd0, 8'd1, 1'b0, 1'b0,
                          ERR_NONE}},
    '{8'h00, 1'b0, 1'b1, '{32'd1, 1'b1, TT_CLOSE, 32'd0, 32'd1, 32'd0, 8'd0, 1'b0, 1'b1,
                          ERR_NONE}},
    '{8'h7f, 1'b1, 1'b0, '0},
    '{8'h7f, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b0, 1'b1, '{32'd4, 1'b0, TT_EXT, 32'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0,
                          ERR_OVERFLOW}},
    '{8'h83, 1'b1, 1'b1, '{32'd0, 1'b0, TT_EXT, 32'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0,
                          ERR_ATTR}},
    '{8'h87, 1'b1, 1'b1, '{32'd0, 1'b0, TT_EXT, 32'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0,
                          ERR_CODING}},
    '{8'h81, 1'b1, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h8b, 1'b0, 1'b0, '0},
    '{8'h61, 1'b0, 1'b0, '0},
    '{8'h62, 1'b0, 1'b0, '0},
    '{8'h8e, 1'b0, 1'b0, '0},
    '{8'h33, 1'b0, 1'b0, '0},
    '{8'h84, 1'b0, 1'b0, '0},
    '{8'h85, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b1, 1'b0, '0},
    '{8'h7f, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b0, 1'b0, '0},
    '{8'hf9, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'hc3, 1'b0, 1'b0, '0}
  };

  stim_row_t   stim_q[$];
  out_beat_t   result_q[$];
  out_beat_t   pred_beat;
  logic        next_restart = 1'b0;
  int unsigned accepted_cnt = 0;
  int unsigned rx_count     = 0;
  int unsigned mismatches   = 0;

  // decoder state mirror
  phase_t     dec_phase;
  logic [1:0] dec_ctx;
  value_t     dec_val;
  depth_t     dec_depth;
  offset_t    dec_count;
  offset_t    dec_tok_begin;
  offset_t    dec_elem_begin;
  err_t       dec_err;

  function automatic void clear_decoder();
    dec_phase      = PH_INITIAL;
    dec_ctx        = TC_NONE;
    dec_val        = '0;
    dec_depth      = '0;
    dec_count      = '0;
    dec_tok_begin  = '0;
    dec_elem_begin = '0;
    dec_err        = ERR_NONE;
  endfunction

  function automatic err_t open_elem();
    if (dec_depth == {DEPTH_BITS{1'b1}}) return ERR_NEST;
    dec_depth      = dec_depth + 1'b1;
    dec_elem_begin = dec_tok_begin;
    return ERR_NONE;
  endfunction

  function automatic out_beat_t decode_byte(in_beat_t b);
    out_beat_t  r;
    logic [7:0] c;
    err_t       e;
    logic       done, pay, fin, hdr;
    tok_t       tt;
    value_t     tv;
    offset_t    off;
    c    = b.data_byte;
    e    = ERR_NONE;
    done = 1'b0;
    pay  = 1'b0;
    fin  = 1'b0;
    hdr  = 1'b0;
    tt   = TT_EXT;
    tv   = '0;
    if (b.restart) clear_decoder();
    off       = dec_count;
    dec_count = dec_count + 1'b1;
    case (dec_phase)
      PH_INITIAL, PH_NEWTOKEN: begin
        dec_tok_begin = off;
        if (dec_ctx > TC_TAG) dec_ctx = dec_ctx - 2'd1;
        if (c == 8'h00) begin
          if (dec_depth == '0 || dec_ctx > TC_TAG) begin
            e = ERR_NEST;
          end else begin
            if (dec_ctx == TC_TAG) dec_ctx = TC_NONE;
            dec_depth = dec_depth - 1'b1;
            done      = 1'b1;
            tt        = TT_CLOSE;
            if (dec_depth == '0) begin
              dec_phase = PH_INITIAL;
              fin       = 1'b1;
            end else begin
              dec_phase = PH_NEWTOKEN;
            end
          end
        end else begin
          dec_val   = '0;
          dec_phase = PH_NUMVAL;
          hdr       = 1'b1;
        end
      end
      PH_NUMVAL: hdr = 1'b1;
      PH_TAGNAME, PH_ATTRNAME, PH_UDATA, PH_BLOB: begin
        pay = 1'b1;
        if (dec_val == '0) begin
          e = ERR_CODING;
        end else begin
          dec_val = dec_val - 1'b1;
          if (dec_val == '0) begin
            if (dec_phase == PH_TAGNAME) begin
              if (dec_depth == '0) e = ERR_NEST;
              else dec_ctx = TC_TAG;
            end else if (dec_phase == PH_ATTRNAME) begin
              if (dec_depth == '0) e = ERR_ATTR;
              else dec_ctx = TC_ATTR;
            end
            dec_phase = PH_NEWTOKEN;
          end
        end
      end
      default: ;
    endcase

    if (hdr) begin
      if (!c[7]) begin
        if (dec_val > OVF_LIMIT) e = ERR_OVERFLOW;
        dec_val = (dec_val << 7) + value_t'(c[6:0]);
      end else begin
        tt      = tok_t'(c[2:0]);
        dec_val = (dec_val << 4) + value_t'(c[6:3]);
        case (tt)
          TT_EXT, TT_DTAG: begin
            if (dec_ctx == TC_TAG) dec_ctx = TC_NONE;
            e = open_elem();
            if (tt == TT_DTAG) dec_ctx = TC_TAG;
            dec_phase = PH_NEWTOKEN;
          end
          TT_TAG: begin
            if (dec_ctx == TC_TAG) dec_ctx = TC_NONE;
            dec_val   = dec_val + 1'b1;
            e         = open_elem();
            dec_phase = PH_TAGNAME;
          end
          TT_ATTR: begin
            if (dec_ctx != TC_TAG) begin
              e = ERR_ATTR;
            end else begin
              dec_val   = dec_val + 1'b1;
              dec_phase = PH_ATTRNAME;
            end
          end
          TT_DATTR: begin
            if (dec_ctx != TC_TAG) begin
              e = ERR_ATTR;
            end else begin
              dec_ctx   = TC_ATTR;
              dec_phase = PH_NEWTOKEN;
            end
          end
          TT_BLOB, TT_UDATA: begin
            if (dec_ctx == TC_TAG) dec_ctx = TC_NONE;
            if (dec_val == '0) dec_phase = PH_NEWTOKEN;
            else dec_phase = (tt == TT_BLOB) ? PH_BLOB : PH_UDATA;
          end
          default: e = ERR_CODING;
        endcase
        done = 1'b1;
        tv   = dec_val;
      end
    end

    if (e != ERR_NONE) begin
      dec_err   = e;
      dec_phase = PH_ERROR;
      dec_ctx   = TC_NONE;
      done      = 1'b0;
      tt        = TT_EXT;
      tv        = '0;
      fin       = 1'b0;
    end

    r.byte_offset   = off_out(off);
    r.token_done    = done;
    r.token_type    = tt;
    r.token_value   = val_out(tv);
    r.token_start   = off_out(dec_tok_begin);
    r.element_start = off_out(dec_elem_begin);
    r.depth         = depth_out(dec_depth);
    r.in_payload    = pay;
    r.message_done  = fin;
    r.error_code    = dec_err;
    return r;
  endfunction

  // stimulus building
  task automatic add_row(in_beat_t b, logic typed, out_beat_t want);
    stim_row_t row;
    row.beat  = b;
    row.typed = typed;
    row.want  = want;
    stim_q.push_back(row);
  endtask

  task automatic add_beat(logic [7:0] data);
    add_row('{data_byte: data, restart: next_restart}, 1'b0, '0);
    next_restart = 1'b0;
  endtask

  task automatic add_header(tok_t t, value_t v);
    value_t hi;
    int     ng;
    hi = v >> 4;
    ng = 0;
    while ((hi >> (7 * ng)) != '0) ng++;
    for (int k = ng - 1; k >= 0; k--) add_beat({1'b0, 7'(hi >> (7 * k))});
    add_beat({1'b1, v[3:0], t});
  endtask

  task automatic add_payload(int n);
    repeat (n) add_beat(8'($urandom));
  endtask

  function automatic value_t rand_value();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel < 4) return value_t'($urandom_range(0, 15));
    if (sel < 6) return value_t'($urandom_range(0, 2047));
    if (sel == 6) return value_t'($urandom);
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return value_t'(32'h0fff_ffff);
    endcase
  endfunction

  task automatic open_element(output logic tag_open);
    int len;
    case ($urandom_range(0, 2))
      0: begin
        add_header(TT_DTAG, rand_value());
        tag_open = 1'b1;
      end
      1: begin
        len = $urandom_range(1, 4);
        add_header(TT_TAG, value_t'(len - 1));
        add_payload(len);
        tag_open = 1'b1;
      end
      default: begin
        add_header(TT_EXT, rand_value());
        tag_open = 1'b0;
      end
    endcase
  endtask

  task automatic build_message();
    int   lvl, steps, k, len, start, idx;
    logic tag_open;
    start        = stim_q.size();
    next_restart = ($urandom_range(0, 3) != 0);
    open_element(tag_open);
    lvl   = 1;
    steps = $urandom_range(0, 10);
    repeat (steps) begin
      k = $urandom_range(0, 9);
      if (k < 3 && tag_open) begin
        if ($urandom_range(0, 1) == 0) begin
          len = $urandom_range(1, 4);
          add_header(TT_ATTR, value_t'(len - 1));
          add_payload(len);
        end else begin
          add_header(TT_DATTR, rand_value());
        end
        len = $urandom_range(0, 3);
        add_header(($urandom_range(0, 1) == 0) ? TT_BLOB : TT_UDATA, value_t'(len));
        add_payload(len);
      end else if (k < 6 && lvl < 5) begin
        open_element(tag_open);
        lvl++;
      end else if (k < 8 || lvl == 1) begin
        len = $urandom_range(0, 4);
        add_header(($urandom_range(0, 1) == 0) ? TT_BLOB : TT_UDATA, value_t'(len));
        add_payload(len);
        tag_open = 1'b0;
      end else begin
        add_beat(8'h00);
        lvl--;
        tag_open = 1'b0;
      end
    end
    repeat (lvl) add_beat(8'h00);
    if ($urandom_range(0, 4) == 0) begin
      idx = $urandom_range(start, stim_q.size() - 1);
      stim_q[idx].beat.data_byte = 8'($urandom);
    end else if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3))
        if (stim_q.size() > start + 1) void'(stim_q.pop_back());
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_beat(out_beat_t want, out_beat_t got);
    check_field("byte_offset", want.byte_offset, got.byte_offset);
    check_field("token_done", want.token_done, got.token_done);
    check_field("token_type", want.token_type, got.token_type);
    check_field("token_value", want.token_value, got.token_value);
    check_field("token_start", want.token_start, got.token_start);
    check_field("element_start", want.element_start, got.element_start);
    check_field("depth", want.depth, got.depth);
    check_field("in_payload", want.in_payload, got.in_payload);
    check_field("message_done", want.message_done, got.message_done);
    check_field("error_code", want.error_code, got.error_code);
  endtask

  // handshake monitor: predict on input beats, compare on output beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pred_beat = decode_byte(stim_q[accepted_cnt].beat);
        if (stim_q[accepted_cnt].typed) result_q.push_back(stim_q[accepted_cnt].want);
        else result_q.push_back(pred_beat);
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        rx_count++;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
          mismatches++;
        end else begin
          check_beat(result_q.pop_front(), out_data);
        end
      end
    end
  end

  // result side: random backpressure, a quiet window and two long hold-offs
  initial begin
    int hold_left;
    int held_at;
    hold_left = 0;
    held_at   = -1;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && (rx_count == 100 || rx_count == 700) && rx_count != held_at) begin
        hold_left = 80;
        held_at   = rx_count;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_count >= 300 && rx_count < 450) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 37);
      end
    end
  end

  initial begin
    int  i;
    bit  deep_done;
    clear_decoder();
    foreach (dir_tab[k])
      add_row('{data_byte: dir_tab[k].data_byte, restart: dir_tab[k].restart},
              dir_tab[k].typed, dir_tab[k].want);
    deep_done = 1'b0;
    while (stim_q.size() < DIR_ROWS + RAND_BEATS) begin
      if (!deep_done && stim_q.size() > 500) begin
        // fill to the deepest nesting, then one open too many
        deep_done    = 1'b1;
        next_restart = 1'b1;
        repeat (256) add_header(TT_DTAG, value_t'($urandom_range(0, 15)));
        add_beat(8'h00);
      end else if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          next_restart = ($urandom_range(0, 7) == 0);
          add_beat(8'($urandom));
        end
      end else begin
        build_message();
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    i = 0;
    while (i < stim_q.size()) begin
      if (!(i >= 300 && i < 450) && $urandom_range(0, 99) < 37) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= stim_q[i].beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        i++;
      end
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS binary_xml_token_decoder_unit");
    end else begin
      $display("FAIL binary_xml_token_decoder_unit");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL binary_xml_token_decoder_unit");
    $finish;
  end

endmodule
